// ----- src/stereo_hrtf_gain_reverb_top_defines.svh -----
// Assertion macros for the stereo HRTF gain and echo block.
// Taken in by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef STEREO_HRTF_GAIN_REVERB_TOP_DEFINES_SVH
`define STEREO_HRTF_GAIN_REVERB_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define SHGR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define SHGR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/shgr_pkg.sv -----
// Shared types, constants, coefficient tables and helper functions of the
// stereo HRTF gain and echo block. No dependencies.
`default_nettype none

package shgr_pkg;

    // sizes
    localparam int LINE_DEPTH  = 4800;
    localparam int ENTRY_COUNT = 8;
    localparam int ADDR_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int DELAY_W     = 13;
    localparam int SUM_W       = ((ADDR_W > DELAY_W) ? ADDR_W : DELAY_W) + 1;
    localparam int ENTRY_W     = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int TAP_W       = 3;
    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 15;
    localparam int OP_W        = 17;
    localparam int PROD_W      = 2 * OP_W;
    localparam int ACC_W       = PROD_W + 1;
    localparam int Q15_SHIFT   = 15;
    localparam int WIDE_W      = ACC_W - Q15_SHIFT;
    localparam int Q15_MAX     = 32767;
    localparam int Q15_ONE     = 32768;
    localparam int FULL_TURN   = 360;
    localparam int HALF_TURN   = 180;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [8:0]          t_azimuth;
    typedef logic        [ENTRY_W-1:0]  t_entry;
    typedef logic        [TAP_W-1:0]    t_tap;
    typedef logic        [ADDR_W-1:0]   t_addr;
    typedef logic        [DELAY_W-1:0]  t_delay;
    typedef logic        [GAIN_W-1:0]   t_gain;
    typedef logic signed [OP_W-1:0]     t_mac_op;
    typedef logic signed [PROD_W-1:0]   t_mac_prod;
    typedef logic signed [ACC_W-1:0]    t_mac_acc;
    typedef logic signed [WIDE_W-1:0]   t_wide;
    typedef logic        [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic        [CFG_DATA_W-1:0] t_cfg_data;

    // register indexes
    localparam t_cfg_idx CFG_SPATIAL_EN = 3'd0;
    localparam t_cfg_idx CFG_BALANCE    = 3'd1;
    localparam t_cfg_idx CFG_REVERB_EN  = 3'd2;
    localparam t_cfg_idx CFG_DELAY      = 3'd3;
    localparam t_cfg_idx CFG_WET        = 3'd4;
    localparam t_cfg_idx CFG_DECAY      = 3'd5;

    // register reset values
    localparam t_delay RST_DELAY = 13'd2400;
    localparam t_gain  RST_WET   = 15'd6553;
    localparam t_gain  RST_DECAY = 15'd9830;

    typedef struct packed {
        logic issue;   // start a multiply this cycle
        logic accum;   // add to accumulator instead of replacing it
    } t_mac_ctl;

    typedef struct packed {
        logic fresh;   // accumulator was updated at the last edge
    } t_mac_stat;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MUL_L,
        S_MUL_R,
        S_CAP_L,
        S_CAP_R,
        S_BAL_MUL,
        S_BAL_WAIT,
        S_BAL_CAP,
        S_RV_DRY_L,
        S_RV_WET_L,
        S_RV_DRY_R,
        S_RV_WET_R,
        S_RV_DEC_L,
        S_RV_CAP_R,
        S_RV_DEC_R,
        S_RV_WAIT,
        S_RV_WR_R,
        S_FIN
    } t_state;

    localparam logic [8:0] ENTRY_AZ [8] = '{
        9'd0, 9'd45, 9'd90, 9'd135, 9'd180, 9'd225, 9'd270, 9'd315
    };

    localparam logic [GAIN_W-1:0] COEF_L [8][8] = '{
        '{15'd32767, 15'd32000, 15'd30000, 15'd28000, 15'd25000, 15'd22000, 15'd19000, 15'd16000},
        '{15'd32767, 15'd31000, 15'd28000, 15'd24000, 15'd20000, 15'd16000, 15'd12000, 15'd8000},
        '{15'd24000, 15'd22000, 15'd18000, 15'd14000, 15'd10000, 15'd7000,  15'd4000,  15'd2000},
        '{15'd20000, 15'd18000, 15'd15000, 15'd12000, 15'd9000,  15'd6000,  15'd4000,  15'd2000},
        '{15'd22000, 15'd20000, 15'd17000, 15'd14000, 15'd11000, 15'd8000,  15'd5000,  15'd3000},
        '{15'd28000, 15'd30000, 15'd32767, 15'd30000, 15'd26000, 15'd22000, 15'd18000, 15'd14000},
        '{15'd32767, 15'd32000, 15'd30000, 15'd28000, 15'd25000, 15'd22000, 15'd19000, 15'd16000},
        '{15'd30000, 15'd32767, 15'd31000, 15'd28000, 15'd24000, 15'd20000, 15'd16000, 15'd12000}
    };

    localparam logic [GAIN_W-1:0] COEF_R [8][8] = '{
        '{15'd32767, 15'd32000, 15'd30000, 15'd28000, 15'd25000, 15'd22000, 15'd19000, 15'd16000},
        '{15'd30000, 15'd32767, 15'd31000, 15'd28000, 15'd24000, 15'd20000, 15'd16000, 15'd12000},
        '{15'd32767, 15'd32000, 15'd30000, 15'd28000, 15'd25000, 15'd22000, 15'd19000, 15'd16000},
        '{15'd28000, 15'd30000, 15'd32767, 15'd30000, 15'd26000, 15'd22000, 15'd18000, 15'd14000},
        '{15'd22000, 15'd20000, 15'd17000, 15'd14000, 15'd11000, 15'd8000,  15'd5000,  15'd3000},
        '{15'd20000, 15'd18000, 15'd15000, 15'd12000, 15'd9000,  15'd6000,  15'd4000,  15'd2000},
        '{15'd24000, 15'd22000, 15'd18000, 15'd14000, 15'd10000, 15'd7000,  15'd4000,  15'd2000},
        '{15'd32767, 15'd31000, 15'd28000, 15'd24000, 15'd20000, 15'd16000, 15'd12000, 15'd8000}
    };

    // Nearest entry by circular distance; strict compare keeps the lower index on ties.
    function automatic t_entry nearest_entry(input t_azimuth az);
        logic [8:0] a;
        logic [8:0] d;
        logic [8:0] best_d;
        t_entry     best;
        a      = (az >= 9'(FULL_TURN)) ? az - 9'(FULL_TURN) : az;
        best_d = 9'(FULL_TURN);
        best   = '0;
        for (int i = 0; i < ENTRY_COUNT; i++) begin
            d = (a >= ENTRY_AZ[i]) ? a - ENTRY_AZ[i] : ENTRY_AZ[i] - a;
            if (d > 9'(HALF_TURN)) begin
                d = 9'(FULL_TURN) - d;
            end
            if (d < best_d) begin
                best_d = d;
                best   = t_entry'(i);
            end
        end
        return best;
    endfunction

    // floor(acc / 2^15)
    function automatic t_wide floor_q15(input t_mac_acc acc);
        return acc[ACC_W-1:Q15_SHIFT];
    endfunction

    // acc / 2^15 rounded toward zero
    function automatic t_wide trunc_q15(input t_mac_acc acc);
        t_mac_acc biased;
        biased = acc + t_mac_acc'(Q15_MAX);
        return acc[ACC_W-1] ? biased[ACC_W-1:Q15_SHIFT] : acc[ACC_W-1:Q15_SHIFT];
    endfunction

    // symmetric clamp to +-32767
    function automatic t_sample sat_sym(input t_wide w);
        if (w > t_wide'(Q15_MAX)) begin
            return t_sample'(Q15_MAX);
        end
        if (w < -t_wide'(Q15_MAX)) begin
            return -t_sample'(Q15_MAX);
        end
        return w[SAMPLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/shgr_if.sv -----
// Handshake channels of the stereo HRTF gain and echo block: input frame
// and output frame. Depends on shgr_pkg.
`default_nettype none

interface shgr_in_if;
    import shgr_pkg::*;
    logic     valid;
    logic     ready;
    t_sample  left_in;
    t_sample  right_in;
    t_azimuth azimuth_deg;
    logic     block_start;
    modport source (output valid, left_in, right_in, azimuth_deg, block_start, input ready);
    modport sink   (input valid, left_in, right_in, azimuth_deg, block_start, output ready);
endinterface

interface shgr_out_if;
    import shgr_pkg::*;
    logic    valid;
    logic    ready;
    t_sample left_out;
    t_sample right_out;
    modport source (output valid, left_out, right_out, input ready);
    modport sink   (input valid, left_out, right_out, output ready);
endinterface

`default_nettype wire

// ----- src/shgr_mac.sv -----
// Shared multiply-accumulate unit: registered 17x17 signed product, then
// a registered accumulate or load. Depends on shgr_pkg.
`default_nettype none

module shgr_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  shgr_pkg::t_mac_ctl  i_ctl,
    input  shgr_pkg::t_mac_op   i_a,
    input  shgr_pkg::t_mac_op   i_b,
    output shgr_pkg::t_mac_acc  o_acc,
    output shgr_pkg::t_mac_stat o_stat
);
    import shgr_pkg::*;

    t_mac_prod r_prod;
    t_mac_acc  r_acc;
    logic      r_p_vld;
    logic      r_p_acc;
    logic      r_fresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_p_acc <= 1'b0;
            r_fresh <= 1'b0;
        end else begin
            r_p_vld <= i_ctl.issue;
            r_p_acc <= i_ctl.accum;
            r_fresh <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (r_p_vld) begin
            r_acc <= r_p_acc ? r_acc + t_mac_acc'(r_prod) : t_mac_acc'(r_prod);
        end
    end

    assign o_acc        = r_acc;
    assign o_stat.fresh = r_fresh;

endmodule

`default_nettype wire

// ----- src/stereo_hrtf_gain_reverb_top.sv -----
// Stereo HRTF gain, balance and single-tap echo: sequencer, registers and echo lines.
// Depends on shgr_pkg, shgr_if (shgr_in_if, shgr_out_if), shgr_mac and the defines header.
`default_nettype none
`include "stereo_hrtf_gain_reverb_top_defines.svh"

// Takes one stereo frame at a time and returns one processed frame. A single
// multiply-accumulate unit (registered product, then registered accumulate) does
// every product under a small sequencer, and the input is not ready while a frame
// is in work. With spatial processing off a frame goes straight to the output
// stage; with it on, the HRTF gain steps are followed by the balance steps when
// balance is nonzero and by the echo steps when the echo is on. The output
// register lets the next frame be taken while a result waits downstream. The echo
// lines are one RAM per channel (LINE_DEPTH words, one access a cycle); there is no
// clearing pass: the write position only moves forward from zero, so a slot counts
// as written when it lies below the write position or the line has wrapped once,
// and an unwritten slot reads as zero. Configuration is taken by a plain write
// port at any time; write it only while no frame is in flight.
module stereo_hrtf_gain_reverb_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  shgr_pkg::t_cfg_idx  i_cfg_idx,
    input  shgr_pkg::t_cfg_data i_cfg_data,
    shgr_in_if.sink             i_frame,
    shgr_out_if.source          o_frame
);
    import shgr_pkg::*;

    // configuration registers
    logic    r_spatial_en;
    t_sample r_balance;
    logic    r_reverb_en;
    t_delay  r_delay;
    t_gain   r_wet;
    t_gain   r_decay;

    // sequencer and frame state
    t_state  r_state;
    t_state  n_state;
    t_tap    r_tap;        // tap for the next frame
    t_tap    r_tap_use;    // tap of the frame in work
    t_entry  r_ent;
    t_sample r_lv;
    t_sample r_rv;

    // echo lines
    t_sample mem_l [LINE_DEPTH];
    t_sample mem_r [LINE_DEPTH];
    t_addr   r_wp;
    logic    r_wrapped;    // every slot has been written at least once
    t_sample r_echo_l;
    t_sample r_echo_r;
    logic    r_echo_ok;

    // output register
    logic    r_out_vld;
    t_sample r_out_l;
    t_sample r_out_r;

    // shared unit
    t_mac_ctl  mac_ctl;
    t_mac_op   mac_a;
    t_mac_op   mac_b;
    t_mac_acc  mac_acc;
    t_mac_stat mac_stat;

    logic           in_acc;
    logic           fin_load;
    logic           rd_en;
    logic           we_l;
    logic           we_r;
    logic           bal_on;
    logic           bal_right;
    t_mac_op        bal_factor;
    t_mac_op        dry_op;
    t_mac_op        echo_l_op;
    t_mac_op        echo_r_op;
    logic [SUM_W-1:0] d_eff;
    logic [SUM_W-1:0] wp_x;
    logic [SUM_W-1:0] rp_x;
    t_addr          rd_addr;
    logic           rd_ok;
    t_sample        line_wdata;
    t_tap           tap_sel;

    assign in_acc        = i_frame.valid && i_frame.ready;
    assign i_frame.ready = (r_state == S_IDLE);
    assign tap_sel       = i_frame.block_start ? '0 : r_tap;

    // balance: negative scales right by (32768+b), positive scales left by (32768-b)
    assign bal_on     = (r_balance != '0);
    assign bal_right  = r_balance[SAMPLE_W-1];
    assign bal_factor = bal_right ? t_mac_op'(Q15_ONE) + t_mac_op'(r_balance)
                                  : t_mac_op'(Q15_ONE) - t_mac_op'(r_balance);
    assign dry_op     = t_mac_op'(Q15_MAX) - t_mac_op'(r_wet);
    assign echo_l_op  = r_echo_ok ? t_mac_op'(r_echo_l) : '0;
    assign echo_r_op  = r_echo_ok ? t_mac_op'(r_echo_r) : '0;

    // read slot: delay clamped to depth; a delay of zero lands on the write slot
    always_comb begin
        d_eff = (SUM_W'(r_delay) > SUM_W'(LINE_DEPTH)) ? SUM_W'(LINE_DEPTH) : SUM_W'(r_delay);
        wp_x  = SUM_W'(r_wp);
        rp_x  = (wp_x >= d_eff) ? wp_x - d_eff : wp_x + SUM_W'(LINE_DEPTH) - d_eff;
    end
    assign rd_addr    = rp_x[ADDR_W-1:0];
    assign rd_ok      = r_wrapped || (rd_addr < r_wp);
    assign line_wdata = t_sample'(floor_q15(mac_acc));

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spatial_en <= 1'b1;
            r_balance    <= '0;
            r_reverb_en  <= 1'b0;
            r_delay      <= RST_DELAY;
            r_wet        <= RST_WET;
            r_decay      <= RST_DECAY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SPATIAL_EN: r_spatial_en <= i_cfg_data[0];
                CFG_BALANCE:    r_balance    <= t_sample'(i_cfg_data);
                CFG_REVERB_EN:  r_reverb_en  <= i_cfg_data[0];
                CFG_DELAY:      r_delay      <= i_cfg_data[DELAY_W-1:0];
                CFG_WET:        r_wet        <= i_cfg_data[GAIN_W-1:0];
                CFG_DECAY:      r_decay      <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and the shared-unit schedule
    always_comb begin
        n_state  = r_state;
        mac_ctl  = '0;
        mac_a    = '0;
        mac_b    = '0;
        rd_en    = 1'b0;
        we_l     = 1'b0;
        we_r     = 1'b0;
        fin_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = r_spatial_en ? S_MUL_L : S_FIN;
                end
            end
            S_MUL_L: begin
                mac_ctl.issue = 1'b1;
                mac_a         = t_mac_op'(r_lv);
                mac_b         = t_mac_op'({1'b0, COEF_L[r_ent][r_tap_use]});
                rd_en         = r_reverb_en;
                n_state       = S_MUL_R;
            end
            S_MUL_R: begin
                mac_ctl.issue = 1'b1;
                mac_a         = t_mac_op'(r_rv);
                mac_b         = t_mac_op'({1'b0, COEF_R[r_ent][r_tap_use]});
                n_state       = S_CAP_L;
            end
            S_CAP_L: begin
                n_state = S_CAP_R;
            end
            S_CAP_R: begin
                priority if (bal_on) begin
                    n_state = S_BAL_MUL;
                end else if (r_reverb_en) begin
                    n_state = S_RV_DRY_L;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_BAL_MUL: begin
                mac_ctl.issue = 1'b1;
                mac_a         = bal_right ? t_mac_op'(r_rv) : t_mac_op'(r_lv);
                mac_b         = bal_factor;
                n_state       = S_BAL_WAIT;
            end
            S_BAL_WAIT: begin
                n_state = S_BAL_CAP;
            end
            S_BAL_CAP: begin
                n_state = r_reverb_en ? S_RV_DRY_L : S_FIN;
            end
            S_RV_DRY_L: begin
                mac_ctl.issue = 1'b1;
                mac_a         = t_mac_op'(r_lv);
                mac_b         = dry_op;
                n_state       = S_RV_WET_L;
            end
            S_RV_WET_L: begin
                mac_ctl = '{issue: 1'b1, accum: 1'b1};
                mac_a   = echo_l_op;
                mac_b   = t_mac_op'(r_wet);
                n_state = S_RV_DRY_R;
            end
            S_RV_DRY_R: begin
                mac_ctl.issue = 1'b1;
                mac_a         = t_mac_op'(r_rv);
                mac_b         = dry_op;
                n_state       = S_RV_WET_R;
            end
            S_RV_WET_R: begin
                // left mix lands in the accumulator this cycle
                mac_ctl = '{issue: 1'b1, accum: 1'b1};
                mac_a   = echo_r_op;
                mac_b   = t_mac_op'(r_wet);
                n_state = S_RV_DEC_L;
            end
            S_RV_DEC_L: begin
                mac_ctl.issue = 1'b1;
                mac_a         = t_mac_op'(r_lv);
                mac_b         = t_mac_op'(r_decay);
                n_state       = S_RV_CAP_R;
            end
            S_RV_CAP_R: begin
                n_state = S_RV_DEC_R;
            end
            S_RV_DEC_R: begin
                mac_ctl.issue = 1'b1;
                mac_a         = t_mac_op'(r_rv);
                mac_b         = t_mac_op'(r_decay);
                we_l          = 1'b1;
                n_state       = S_RV_WAIT;
            end
            S_RV_WAIT: begin
                n_state = S_RV_WR_R;
            end
            S_RV_WR_R: begin
                we_r    = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_vld || o_frame.ready) begin
                    fin_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // tap index, write position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap     <= '0;
            r_wp      <= '0;
            r_wrapped <= 1'b0;
        end else begin
            if (in_acc && r_spatial_en) begin
                r_tap <= tap_sel + 1'b1;
            end
            if (we_r) begin
                if (SUM_W'(r_wp) == SUM_W'(LINE_DEPTH - 1)) begin
                    r_wp      <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_wp <= r_wp + 1'b1;
                end
            end
        end
    end

    // frame datapath: capture points follow the unit's product and accumulator registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_lv      <= i_frame.left_in;
                    r_rv      <= i_frame.right_in;
                    r_ent     <= nearest_entry(i_frame.azimuth_deg);
                    r_tap_use <= tap_sel;
                end
            end
            S_CAP_L:    r_lv <= sat_sym(floor_q15(mac_acc));
            S_CAP_R:    r_rv <= sat_sym(floor_q15(mac_acc));
            S_BAL_CAP: begin
                if (bal_right) begin
                    r_rv <= sat_sym(trunc_q15(mac_acc));
                end else begin
                    r_lv <= sat_sym(trunc_q15(mac_acc));
                end
            end
            S_RV_WET_R: r_lv <= sat_sym(floor_q15(mac_acc));
            S_RV_CAP_R: r_rv <= sat_sym(floor_q15(mac_acc));
            default: ;
        endcase
    end

    // echo line RAMs, read data registered
    always_ff @(posedge i_clk) begin
        if (we_l) begin
            mem_l[r_wp] <= line_wdata;
        end
        if (rd_en) begin
            r_echo_l <= mem_l[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_r) begin
            mem_r[r_wp] <= line_wdata;
        end
        if (rd_en) begin
            r_echo_r <= mem_r[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_ok <= 1'b0;
        end else if (rd_en) begin
            r_echo_ok <= rd_ok;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fin_load) begin
            r_out_vld <= 1'b1;
        end else if (o_frame.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_load) begin
            r_out_l <= r_lv;
            r_out_r <= r_rv;
        end
    end

    assign o_frame.valid     = r_out_vld;
    assign o_frame.left_out  = r_out_l;
    assign o_frame.right_out = r_out_r;

    shgr_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc   (mac_acc),
        .o_stat  (mac_stat)
    );

    // every capture or line write must see a result the unit has just produced
    `SHGR_ASSERT_IMP(a_capture_fresh, i_clk, i_rst_n,
        (r_state == S_CAP_L || r_state == S_CAP_R || r_state == S_BAL_CAP || r_state == S_RV_WET_R || r_state == S_RV_CAP_R || r_state == S_RV_DEC_R || r_state == S_RV_WR_R),
        mac_stat.fresh, "capture without a fresh accumulator")
    `SHGR_ASSERT_IMP(a_wp_range, i_clk, i_rst_n, 1'b1,
        (SUM_W'(r_wp) < SUM_W'(LINE_DEPTH)), "write position beyond line depth")
    `SHGR_ASSERT_NXT(a_wp_hold, i_clk, i_rst_n, (r_state != S_RV_WR_R),
        (r_wp == $past(r_wp)), "write position moved outside the echo write")
    `SHGR_ASSERT_NXT(a_bypass_direct, i_clk, i_rst_n, (in_acc && !r_spatial_en),
        (r_state == S_FIN), "bypassed item did not go straight to the output")

endmodule

`default_nettype wire
